/* rtl/cpr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package cpr_pkg;

    // Build-time sizing
    localparam int MAX_FRAMES   = 8;
    localparam int PAGE_BITS    = 20;
    localparam int CFG_W        = 4;
    localparam int FRAMES_RESET = 8;
    localparam int FAULT_W      = 32;
    localparam int FRAME_IDX_W  = 3;

    // Hand / frame index width and active-count width
    localparam int FRAME_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CNT_W   = $clog2(MAX_FRAMES + 1);

    // Controller -> datapath commands
    typedef struct packed {
        logic load;    // capture request payload
        logic look;    // lookup, hit update or fault count
        logic sweep;   // one clock-hand step
        logic commit;  // load result register, clear table on last reference
    } t_cmd;

    // Datapath -> controller status
    typedef struct packed {
        logic hit;     // page found in an active frame
        logic victim;  // frame under the hand is empty or unreferenced
    } t_sts;

    // Frame count in effect: zero acts as one, clamp at the built maximum
    function automatic logic [CNT_W-1:0] active_frames(input logic [CFG_W-1:0] cfg);
        int c;
        c = int'(cfg);
        if (c == 0) c = 1;
        if (c > MAX_FRAMES) c = MAX_FRAMES;
        return CNT_W'(c);
    endfunction

    // Frame number onto the fixed-width result field
    function automatic logic [FRAME_IDX_W-1:0] to_frame_idx(input logic [FRAME_W-1:0] f);
        logic [FRAME_W+FRAME_IDX_W-1:0] w;
        w = {{FRAME_IDX_W{1'b0}}, f};
        return w[FRAME_IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/cpr_req_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface cpr_req_if
    import cpr_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [PAGE_BITS-1:0] page_number;
    logic                 last_reference;

    modport source (output valid, output page_number, output last_reference, input ready);
    modport sink   (input valid, input page_number, input last_reference, output ready);
endinterface

`default_nettype wire

/* rtl/cpr_rsp_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface cpr_rsp_if
    import cpr_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic                   hit;
    logic [FRAME_IDX_W-1:0] frame_index;
    logic                   evicted_valid;
    logic [PAGE_BITS-1:0]   evicted_page;
    logic [FAULT_W-1:0]     fault_count;

    modport source (output valid, output hit, output frame_index, output evicted_valid,
                    output evicted_page, output fault_count, input ready);
    modport sink   (input valid, input hit, input frame_index, input evicted_valid,
                    input evicted_page, input fault_count, output ready);
endinterface

`default_nettype wire

/* rtl/cpr_cfg_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface cpr_cfg_if
    import cpr_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] frames_in_use;

    modport source (output valid, output frames_in_use, input ready);
    modport sink   (input valid, input frames_in_use, output ready);
endinterface

`default_nettype wire

/* rtl/clock_page_replacement.sv */
// Sequence: a hit's result goes valid after the LOOK and DONE states that follow the
// request transaction; a fault's also passes through k = 1 .. N + 1 SWEEP clock-hand
// steps, N the active frame count (frames_in_use, zero as one, at most MAX_FRAMES).
// One reference at a time; sweep one frame per cycle; a waiting result stalls the next.
// Reset (synchronous, active low): all frames empty, reference bits, hand and fault
// count zero, frames_in_use 8; no clearing pass, requests taken at once.
`timescale 1ns / 1ps
`default_nettype none

module clock_page_replacement
    import cpr_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    cpr_req_if.sink   i_req,
    cpr_rsp_if.source o_rsp,
    cpr_cfg_if.sink   i_cfg
);

    t_cmd cmd;
    t_sts sts;

    // Sequencer
    cpr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Frame table and result datapath
    cpr_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg.valid),
        .o_cfg_ready      (i_cfg.ready),
        .i_cfg_frames     (i_cfg.frames_in_use),
        .i_page_number    (i_req.page_number),
        .i_last_reference (i_req.last_reference),
        .o_hit            (o_rsp.hit),
        .o_frame_index    (o_rsp.frame_index),
        .o_evicted_valid  (o_rsp.evicted_valid),
        .o_evicted_page   (o_rsp.evicted_page),
        .o_fault_count    (o_rsp.fault_count),
        .i_cmd            (cmd),
        .o_sts            (sts)
    );

endmodule

`default_nettype wire

/* rtl/cpr_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module cpr_ctrl
    import cpr_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_req_valid,
    output logic o_req_ready,
    output logic o_rsp_valid,
    input  wire  i_rsp_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_LOOK  = 4'b0010,
        S_SWEEP = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        n_out_valid = r_out_valid & ~i_rsp_ready;
        unique case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_LOOK;
                end
            end
            S_LOOK: begin
                o_cmd.look = 1'b1;
                n_state    = i_sts.hit ? S_DONE : S_SWEEP;
            end
            S_SWEEP: begin
                o_cmd.sweep = 1'b1;
                if (i_sts.victim) n_state = S_DONE;
            end
            S_DONE: begin
                // result register free or draining this cycle
                if (!r_out_valid || i_rsp_ready) begin
                    o_cmd.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_rsp_valid = r_out_valid;

endmodule

`default_nettype wire

/* rtl/cpr_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module cpr_dp
    import cpr_pkg::*;
(
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    // configuration
    input  wire                    i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire  [CFG_W-1:0]       i_cfg_frames,
    // request payload
    input  wire  [PAGE_BITS-1:0]   i_page_number,
    input  wire                    i_last_reference,
    // result payload
    output logic                   o_hit,
    output logic [FRAME_IDX_W-1:0] o_frame_index,
    output logic                   o_evicted_valid,
    output logic [PAGE_BITS-1:0]   o_evicted_page,
    output logic [FAULT_W-1:0]     o_fault_count,
    // control
    input  t_cmd                   i_cmd,
    output t_sts                   o_sts
);

    // Frame table
    logic [PAGE_BITS-1:0]  r_pages [MAX_FRAMES];
    logic [MAX_FRAMES-1:0] r_valid;
    logic [MAX_FRAMES-1:0] r_ref;
    logic [FRAME_W-1:0]    r_hand;
    logic [FAULT_W-1:0]    r_faults;
    logic [CFG_W-1:0]      r_frames;

    // Captured request
    logic [PAGE_BITS-1:0]  r_page;
    logic                  r_last;

    // Result being built
    logic                  r_res_hit;
    logic [FRAME_W-1:0]    r_res_frame;
    logic                  r_res_ev_valid;
    logic [PAGE_BITS-1:0]  r_res_ev_page;

    // Output register
    logic                   r_o_hit;
    logic [FRAME_IDX_W-1:0] r_o_frame;
    logic                   r_o_ev_valid;
    logic [PAGE_BITS-1:0]   r_o_ev_page;
    logic [FAULT_W-1:0]     r_o_faults;

    logic [CNT_W-1:0]   n_act;
    logic               hit;
    logic [FRAME_W-1:0] hit_idx;
    logic               victim;
    logic [CNT_W-1:0]   hand_inc;
    logic [FRAME_W-1:0] hand_adv;
    logic [FRAME_W-1:0] hand_start;

    assign n_act = active_frames(r_frames);

    // Parallel lookup over active frames, lowest match wins
    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = 0; i < MAX_FRAMES; i++) begin
            if (!hit && (CNT_W'(i) < n_act) && r_valid[i] && (r_pages[i] == r_page)) begin
                hit     = 1'b1;
                hit_idx = FRAME_W'(i);
            end
        end
    end

    // Hand arithmetic
    assign victim     = !r_valid[r_hand] || !r_ref[r_hand];
    assign hand_inc   = CNT_W'(r_hand) + 1'b1;
    assign hand_adv   = (hand_inc == n_act) ? '0 : hand_inc[FRAME_W-1:0];
    assign hand_start = (CNT_W'(r_hand) >= n_act) ? '0 : r_hand;

    assign o_sts.hit    = hit;
    assign o_sts.victim = victim;
    assign o_cfg_ready  = 1'b1;

    // Control state: valid/reference bits, hand, fault count, frame count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_ref    <= '0;
            r_hand   <= '0;
            r_faults <= '0;
            r_frames <= CFG_W'(FRAMES_RESET);
        end else begin
            if (i_cfg_valid) r_frames <= i_cfg_frames;
            if (i_cmd.look) begin
                if (hit) begin
                    r_ref[hit_idx] <= 1'b1;
                end else begin
                    if (r_faults != '1) r_faults <= r_faults + 1'b1;
                    r_hand <= hand_start;
                end
            end
            if (i_cmd.sweep) begin
                if (victim) begin
                    r_valid[r_hand] <= 1'b1;
                    r_ref[r_hand]   <= 1'b1;
                end else begin
                    r_ref[r_hand]   <= 1'b0;
                end
                r_hand <= hand_adv;
            end
            if (i_cmd.commit && r_last) begin
                r_valid  <= '0;
                r_ref    <= '0;
                r_hand   <= '0;
                r_faults <= '0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_page <= i_page_number;
            r_last <= i_last_reference;
        end
        if (i_cmd.look) begin
            r_res_hit      <= hit;
            r_res_frame    <= hit_idx;
            r_res_ev_valid <= 1'b0;
            r_res_ev_page  <= '0;
        end
        if (i_cmd.sweep && victim) begin
            r_pages[r_hand] <= r_page;
            r_res_frame     <= r_hand;
            r_res_ev_valid  <= r_valid[r_hand];
            r_res_ev_page   <= r_valid[r_hand] ? r_pages[r_hand] : '0;
        end
        if (i_cmd.commit) begin
            r_o_hit      <= r_res_hit;
            r_o_frame    <= to_frame_idx(r_res_frame);
            r_o_ev_valid <= r_res_ev_valid;
            r_o_ev_page  <= r_res_ev_page;
            r_o_faults   <= r_faults;
        end
    end

    assign o_hit           = r_o_hit;
    assign o_frame_index   = r_o_frame;
    assign o_evicted_valid = r_o_ev_valid;
    assign o_evicted_page  = r_o_ev_page;
    assign o_fault_count   = r_o_faults;

endmodule

`default_nettype wire

/* rtl/cpr_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module cpr_props
    import cpr_pkg::*;
(
    input wire                   i_clk,
    input wire                   i_rst_n,
    input wire                   i_rsp_valid,
    input wire                   i_rsp_ready,
    input wire                   i_hit,
    input wire                   i_evicted_valid,
    input wire [PAGE_BITS-1:0]   i_evicted_page,
    input wire [FAULT_W-1:0]     i_fault_count
);

    // No result right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("result valid right after reset");

    // Stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_fault_count)
            && $stable(i_evicted_page) && $stable(i_hit))
        else $error("stalled result changed");

    // A hit never evicts
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_hit |-> !i_evicted_valid && (i_evicted_page == '0))
        else $error("hit reports an eviction");

    // A fault always counts
    a_fault_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_hit |-> (i_fault_count != '0))
        else $error("fault with zero fault count");

    // No eviction means evicted page reads zero
    a_evict_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_evicted_valid |-> (i_evicted_page == '0))
        else $error("evicted page nonzero without eviction");

endmodule

bind clock_page_replacement cpr_props u_cpr_props (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_rsp_valid     (o_rsp.valid),
    .i_rsp_ready     (o_rsp.ready),
    .i_hit           (o_rsp.hit),
    .i_evicted_valid (o_rsp.evicted_valid),
    .i_evicted_page  (o_rsp.evicted_page),
    .i_fault_count   (o_rsp.fault_count)
);

`default_nettype wire
